/* rtl/mbrtu_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mbrtu_pkg
// shared types, constants and the crc byte step for the modbus rtu slave
// ----------------------------------------------------------------------------
package mbrtu_pkg;

    localparam int DEPTH_DEF     = 16;
    localparam int FRAME_MAX_DEF = 64;

    localparam logic [7:0]  FC_READ   = 8'h03;
    localparam logic [7:0]  FC_WRITE  = 8'h10;
    localparam logic [7:0]  EXC_FLAG  = 8'h80;
    localparam logic [7:0]  EXC_FUNC  = 8'h01;
    localparam logic [7:0]  EXC_ADDR  = 8'h02;
    localparam logic [7:0]  EXC_QTY   = 8'h03;
    localparam logic [15:0] CRC_INIT  = 16'hFFFF;
    localparam logic [15:0] CRC_POLY  = 16'hA001;

    localparam logic [1:0] REG_SLAVE = 2'd0;
    localparam logic [1:0] REG_FIRST = 2'd1;
    localparam logic [1:0] REG_COUNT = 2'd2;

    typedef struct packed {
        logic [7:0] rx_byte;
        logic       frame_end;
    } rx_item_t;

    typedef struct packed {
        logic [7:0] tx_byte;
        logic       tx_last;
    } tx_item_t;

    typedef enum logic [4:0] {
        ST_RX,
        ST_CLR,
        ST_HDR0,
        ST_HDR1,
        ST_HDR2,
        ST_HDR3,
        ST_HDR4,
        ST_HDR5,
        ST_HDR6,
        ST_DECIDE,
        ST_WR_HI,
        ST_WR_LO,
        ST_WR_PUT,
        ST_RD_REQ,
        ST_RD_WAIT,
        ST_EMIT,
        ST_CRC_LO,
        ST_CRC_HI
    } state_t;

    function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int i = 0; i < 8; i++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage
`default_nettype wire

/* rtl/mbrtu_ram.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mbrtu_ram
// generic simple dual-port synchronous ram (one write, one read port) with registered read
// ----------------------------------------------------------------------------
module mbrtu_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire                      aclk,
    input  wire                      we,
    input  wire [$clog2(DEPTH)-1:0]  waddr,
    input  wire [WIDTH-1:0]          wdata,
    input  wire [$clog2(DEPTH)-1:0]  raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

/* rtl/modbus_rtu_slave_frame_handler.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// modbus_rtu_slave_frame_handler
// modbus rtu slave serving read (03) and write multiple (16) holding registers
// ----------------------------------------------------------------------------
// Each received byte is written into a frame memory and folded into a running
// crc as it is taken, so s_ready stays high between the bytes of a frame. On
// the byte marked frame_end the frame is checked and served from the frame
// memory and the holding word memory, both simple dual port with registered
// read: the header is read in ST_HDR0 to ST_HDR6, each written word is read
// byte by byte and stored (ST_WR_HI, ST_WR_LO, ST_WR_PUT), each read word is
// fetched (ST_RD_REQ, ST_RD_WAIT) and response bytes go out as m_ready takes
// them. After reset the holding memory is cleared, DEPTH words rounded up to
// a power of two, before any byte is taken, and none while a frame is served.
module modbus_rtu_slave_frame_handler #(
    parameter int DEPTH     = mbrtu_pkg::DEPTH_DEF,
    parameter int FRAME_MAX = mbrtu_pkg::FRAME_MAX_DEF
) (
    input  wire                  aclk,
    input  wire                  aresetn,
    input  wire                  cfg_we,
    input  wire [1:0]            cfg_index,
    input  wire [15:0]           cfg_data,
    input  wire                  s_valid,
    output logic                 s_ready,
    input  wire mbrtu_pkg::rx_item_t s_data,
    output logic                 m_valid,
    input  wire                  m_ready,
    output mbrtu_pkg::tx_item_t  m_data
);
    localparam int FA = $clog2(FRAME_MAX);
    localparam int WA = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int LW = $clog2(FRAME_MAX + 1);
    localparam int RD = 1 << WA;

    // configuration
    logic [7:0]  slave_reg;
    logic [15:0] first_reg;
    logic [4:0]  count_cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            slave_reg     <= '0;
            first_reg     <= '0;
            count_cfg_reg <= '0;
        end else if (cfg_we) begin
            case (cfg_index)
                mbrtu_pkg::REG_SLAVE: slave_reg     <= cfg_data[7:0];
                mbrtu_pkg::REG_FIRST: first_reg     <= cfg_data;
                mbrtu_pkg::REG_COUNT: count_cfg_reg <= cfg_data[4:0];
                default: ;
            endcase
        end
    end

    logic [5:0] count;
    assign count = ({1'b0, count_cfg_reg} < 6'(DEPTH)) ? {1'b0, count_cfg_reg} : 6'(DEPTH);

    // state
    mbrtu_pkg::state_t state_reg, state_next;
    logic [LW-1:0] len_reg, len_next;
    logic          ovf_reg, ovf_next;
    logic [15:0]   crc_reg, crc_next;
    logic [15:0]   tcrc_reg, tcrc_next;
    logic [7:0]    fc_reg, fc_next;
    logic [15:0]   addr_reg, addr_next;
    logic [15:0]   qty_reg, qty_next;
    logic [7:0]    bc_reg, bc_next;
    logic [7:0]    id_reg, id_next;
    logic [16:0]   offs_reg, offs_next;
    logic [16:0]   k_reg, k_next;
    logic [7:0]    hi_reg, hi_next;
    logic [7:0]    code_reg, code_next;
    logic [15:0]   word_reg, word_next;
    logic          wpart_reg, wpart_next;
    logic          rdmode_reg, rdmode_next;

    // frame memory
    logic          f_we;
    logic [FA-1:0] f_waddr, f_raddr;
    logic [7:0]    f_rdata;
    // word memory
    logic          w_we;
    logic [WA-1:0] w_waddr, w_raddr;
    logic [15:0]   w_wdata, w_rdata;

    mbrtu_ram #(.WIDTH(8), .DEPTH(FRAME_MAX)) u_frame (
        .aclk(aclk), .we(f_we), .waddr(f_waddr), .wdata(s_data.rx_byte),
        .raddr(f_raddr), .rdata(f_rdata)
    );

    mbrtu_ram #(.WIDTH(16), .DEPTH(RD)) u_words (
        .aclk(aclk), .we(w_we), .waddr(w_waddr), .wdata(w_wdata),
        .raddr(w_raddr), .rdata(w_rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= mbrtu_pkg::ST_CLR;
            len_reg    <= '0;
            ovf_reg    <= 1'b0;
            crc_reg    <= mbrtu_pkg::CRC_INIT;
            k_reg      <= '0;
        end else begin
            state_reg  <= state_next;
            len_reg    <= len_next;
            ovf_reg    <= ovf_next;
            crc_reg    <= crc_next;
            k_reg      <= k_next;
        end
        tcrc_reg   <= tcrc_next;
        fc_reg     <= fc_next;
        addr_reg   <= addr_next;
        qty_reg    <= qty_next;
        bc_reg     <= bc_next;
        id_reg     <= id_next;
        offs_reg   <= offs_next;
        hi_reg     <= hi_next;
        code_reg   <= code_next;
        word_reg   <= word_next;
        wpart_reg  <= wpart_next;
        rdmode_reg <= rdmode_next;
    end

    logic [15:0] crc_upd;
    logic [16:0] last_addr;
    logic [7:0]  emit_byte;
    logic        emit_go;

    always_comb begin
        state_next  = state_reg;
        len_next    = len_reg;
        ovf_next    = ovf_reg;
        crc_next    = crc_reg;
        tcrc_next   = tcrc_reg;
        fc_next     = fc_reg;
        addr_next   = addr_reg;
        qty_next    = qty_reg;
        bc_next     = bc_reg;
        id_next     = id_reg;
        offs_next   = offs_reg;
        k_next      = k_reg;
        hi_next     = hi_reg;
        code_next   = code_reg;
        word_next   = word_reg;
        wpart_next  = wpart_reg;
        rdmode_next = rdmode_reg;
        s_ready     = 1'b0;
        m_valid     = 1'b0;
        m_data      = '0;
        f_we        = 1'b0;
        f_waddr     = len_reg[FA-1:0];
        f_raddr     = '0;
        w_we        = 1'b0;
        w_waddr     = k_reg[WA-1:0];
        w_wdata     = '0;
        w_raddr     = '0;
        crc_upd     = mbrtu_pkg::crc_byte(crc_reg, s_data.rx_byte);
        last_addr   = {1'b0, first_reg} + 17'(count);
        emit_byte   = '0;
        emit_go     = 1'b0;

        case (state_reg)
            mbrtu_pkg::ST_CLR: begin
                w_we    = 1'b1;
                w_waddr = k_reg[WA-1:0];
                k_next  = k_reg + 17'd1;
                if (k_reg == 17'(RD - 1)) begin
                    state_next = mbrtu_pkg::ST_RX;
                end
            end
            mbrtu_pkg::ST_RX: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    if (len_reg < LW'(FRAME_MAX)) begin
                        f_we     = 1'b1;
                        len_next = len_reg + LW'(1);
                    end else begin
                        ovf_next = 1'b1;
                    end
                    crc_next = crc_upd;
                    if (s_data.frame_end) begin
                        len_next = '0;
                        ovf_next = 1'b0;
                        crc_next = mbrtu_pkg::CRC_INIT;
                        if (!(ovf_reg || len_reg == LW'(FRAME_MAX))
                            && crc_upd == 16'h0 && len_reg >= LW'(7)) begin
                            // keep the frame length for the byte count check
                            k_next     = 17'(len_reg) + 17'd1;
                            state_next = mbrtu_pkg::ST_HDR0;
                        end
                    end
                end
            end
            mbrtu_pkg::ST_HDR0: begin
                f_raddr    = FA'(0);
                state_next = mbrtu_pkg::ST_HDR1;
            end
            mbrtu_pkg::ST_HDR1: begin
                f_raddr    = FA'(1);
                id_next    = f_rdata;
                state_next = mbrtu_pkg::ST_HDR2;
            end
            mbrtu_pkg::ST_HDR2: begin
                f_raddr    = FA'(2);
                fc_next    = f_rdata;
                if (id_reg != slave_reg) begin
                    state_next = mbrtu_pkg::ST_RX;
                end else begin
                    state_next = mbrtu_pkg::ST_HDR3;
                end
            end
            mbrtu_pkg::ST_HDR3: begin
                f_raddr         = FA'(3);
                addr_next[15:8] = f_rdata;
                state_next      = mbrtu_pkg::ST_HDR4;
            end
            mbrtu_pkg::ST_HDR4: begin
                f_raddr        = FA'(4);
                addr_next[7:0] = f_rdata;
                state_next     = mbrtu_pkg::ST_HDR5;
            end
            mbrtu_pkg::ST_HDR5: begin
                f_raddr        = FA'(5);
                qty_next[15:8] = f_rdata;
                state_next     = mbrtu_pkg::ST_HDR6;
            end
            mbrtu_pkg::ST_HDR6: begin
                f_raddr        = FA'(6);
                qty_next[7:0]  = f_rdata;
                offs_next      = {1'b0, addr_reg} - {1'b0, first_reg};
                state_next     = mbrtu_pkg::ST_DECIDE;
            end
            mbrtu_pkg::ST_DECIDE: begin
                bc_next   = f_rdata;
                code_next = '0;
                tcrc_next = mbrtu_pkg::CRC_INIT;
                if (fc_reg != mbrtu_pkg::FC_READ && fc_reg != mbrtu_pkg::FC_WRITE) begin
                    code_next  = mbrtu_pkg::EXC_FUNC;
                    state_next = mbrtu_pkg::ST_EMIT;
                end else if (addr_reg < first_reg || {1'b0, addr_reg} >= last_addr) begin
                    code_next  = mbrtu_pkg::EXC_ADDR;
                    state_next = mbrtu_pkg::ST_EMIT;
                end else if (fc_reg == mbrtu_pkg::FC_READ) begin
                    rdmode_next = 1'b1;
                    if (offs_reg + {1'b0, qty_reg} > 17'(count)) begin
                        code_next  = mbrtu_pkg::EXC_QTY;
                        state_next = mbrtu_pkg::ST_EMIT;
                    end else begin
                        state_next = mbrtu_pkg::ST_EMIT;
                    end
                end else begin
                    rdmode_next = 1'b0;
                    if (f_rdata != 8'd0 && ({qty_reg, 1'b0} != {9'd0, f_rdata}
                        || {9'd0, f_rdata} + 17'd9 > k_reg)) begin
                        code_next  = mbrtu_pkg::EXC_QTY;
                        state_next = mbrtu_pkg::ST_EMIT;
                    end else begin
                        k_next     = '0;
                        state_next = mbrtu_pkg::ST_WR_HI;
                    end
                end
                if (state_next == mbrtu_pkg::ST_EMIT) begin
                    k_next = '0;
                end
            end
            mbrtu_pkg::ST_WR_HI: begin
                // k counts words; stop at bc/2
                if (k_reg >= 17'(bc_reg[7:1])) begin
                    state_next = mbrtu_pkg::ST_EMIT;
                end else if (offs_reg + k_reg >= 17'(count)) begin
                    code_next  = mbrtu_pkg::EXC_QTY;
                    state_next = mbrtu_pkg::ST_EMIT;
                end else begin
                    f_raddr    = FA'(17'd7 + {k_reg[15:0], 1'b0});
                    state_next = mbrtu_pkg::ST_WR_LO;
                end
                if (state_next == mbrtu_pkg::ST_EMIT) begin
                    k_next = '0;
                end
            end
            mbrtu_pkg::ST_WR_LO: begin
                f_raddr    = FA'(17'd8 + {k_reg[15:0], 1'b0});
                hi_next    = f_rdata;
                state_next = mbrtu_pkg::ST_WR_PUT;
            end
            mbrtu_pkg::ST_WR_PUT: begin
                w_we       = 1'b1;
                w_waddr    = WA'(offs_reg + k_reg);
                w_wdata    = {hi_reg, f_rdata};
                k_next     = k_reg + 17'd1;
                state_next = mbrtu_pkg::ST_WR_HI;
            end
            mbrtu_pkg::ST_RD_REQ: begin
                // response byte 3 carries the high byte of the first word
                w_raddr    = WA'(offs_reg + {1'b0, k_reg[16:1]} - 17'd1);
                state_next = mbrtu_pkg::ST_RD_WAIT;
            end
            mbrtu_pkg::ST_RD_WAIT: begin
                word_next  = w_rdata;
                wpart_next = 1'b1;
                state_next = mbrtu_pkg::ST_EMIT;
            end
            mbrtu_pkg::ST_EMIT: begin
                // k indexes response bytes before the crc
                emit_go = 1'b1;
                if (code_reg != 8'd0) begin
                    case (k_reg[1:0])
                        2'd0:    emit_byte = id_reg;
                        2'd1:    emit_byte = fc_reg | mbrtu_pkg::EXC_FLAG;
                        default: emit_byte = code_reg;
                    endcase
                end else if (rdmode_reg) begin
                    if (k_reg == 17'd0) begin
                        emit_byte = id_reg;
                    end else if (k_reg == 17'd1) begin
                        emit_byte = fc_reg;
                    end else if (k_reg == 17'd2) begin
                        emit_byte = qty_reg[6:0] << 1;
                    end else if (!wpart_reg) begin
                        emit_go    = 1'b0;
                        state_next = mbrtu_pkg::ST_RD_REQ;
                    end else begin
                        emit_byte = k_reg[0] ? word_reg[15:8] : word_reg[7:0];
                    end
                end else begin
                    case (k_reg[2:0])
                        3'd0:    emit_byte = id_reg;
                        3'd1:    emit_byte = fc_reg;
                        3'd2:    emit_byte = addr_reg[15:8];
                        3'd3:    emit_byte = addr_reg[7:0];
                        3'd4:    emit_byte = qty_reg[15:8];
                        default: emit_byte = qty_reg[7:0];
                    endcase
                end
                if (emit_go) begin
                    m_valid         = 1'b1;
                    m_data.tx_byte  = emit_byte;
                    m_data.tx_last  = 1'b0;
                    if (m_ready) begin
                        tcrc_next = mbrtu_pkg::crc_byte(tcrc_reg, emit_byte);
                        k_next    = k_reg + 17'd1;
                        if (rdmode_reg && code_reg == 8'd0 && k_reg >= 17'd3
                            && !k_reg[0]) begin
                            wpart_next = 1'b0;
                        end
                        if ((code_reg != 8'd0 && k_reg == 17'd2)
                            || (code_reg == 8'd0 && !rdmode_reg && k_reg == 17'd5)
                            || (code_reg == 8'd0 && rdmode_reg
                                && k_reg == 17'd2 + {qty_reg, 1'b0})) begin
                            state_next = mbrtu_pkg::ST_CRC_LO;
                        end
                    end
                end
            end
            mbrtu_pkg::ST_CRC_LO: begin
                m_valid        = 1'b1;
                m_data.tx_byte = tcrc_reg[7:0];
                if (m_ready) begin
                    state_next = mbrtu_pkg::ST_CRC_HI;
                end
            end
            mbrtu_pkg::ST_CRC_HI: begin
                m_valid        = 1'b1;
                m_data.tx_byte = tcrc_reg[15:8];
                m_data.tx_last = 1'b1;
                if (m_ready) begin
                    state_next = mbrtu_pkg::ST_RX;
                end
            end
            default: begin
                state_next = mbrtu_pkg::ST_RX;
            end
        endcase
        if (state_reg == mbrtu_pkg::ST_DECIDE) begin
            wpart_next = 1'b0;
        end
    end
endmodule
`default_nettype wire

/* bench/modbus_rtu_slave_frame_handler_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// modbus_rtu_slave_frame_handler_checker
// watches the request and response channels, predicts every response byte
// from its own model of the slave and compares it against the block output
// ----------------------------------------------------------------------------
module modbus_rtu_slave_frame_handler_checker
    import mbrtu_pkg::*;
#(
    parameter int DEPTH     = DEPTH_DEF,
    parameter int FRAME_MAX = FRAME_MAX_DEF
) (
    input  wire        aclk,
    input  wire        aresetn,
    input  wire        cfg_we,
    input  wire [1:0]  cfg_index,
    input  wire [15:0] cfg_data,
    input  wire        s_valid,
    input  wire        s_ready,
    input  rx_item_t   s_data,
    input  wire        m_valid,
    input  wire        m_ready,
    input  tx_item_t   m_data,
    output int         fail_count,
    output int         pending,
    output int         results_seen
);

    logic [7:0]  frame_buf [FRAME_MAX];
    int unsigned frame_len;
    bit          frame_ovf;
    logic [15:0] rx_crc;
    logic [15:0] reg_words [DEPTH];
    logic [7:0]  my_slave;
    logic [15:0] my_first;
    logic [4:0]  my_count;
    tx_item_t    response_q [$];

    function automatic logic [15:0] crc_step(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int i = 0; i < 8; i++) begin
            if (c[0]) c = (c >> 1) ^ 16'hA001;
            else c = c >> 1;
        end
        return c;
    endfunction

    task automatic take_byte(input rx_item_t it);
        logic [7:0]  rsp [$];
        int unsigned len, cnt, addr, qty, offs, bc;
        bit          ovf;
        logic [15:0] c;
        logic [7:0]  fc, code;
        tx_item_t    t;
        code = 8'h00;
        if (frame_len < FRAME_MAX) begin
            frame_buf[frame_len] = it.rx_byte;
            frame_len++;
        end else begin
            frame_ovf = 1'b1;
        end
        rx_crc = crc_step(rx_crc, it.rx_byte);
        if (!it.frame_end) return;
        len = frame_len;
        ovf = frame_ovf;
        c = rx_crc;
        frame_len = 0;
        frame_ovf = 1'b0;
        rx_crc = CRC_INIT;
        // silent drops
        if (len < 8 || ovf || c != 16'h0000 || frame_buf[0] != my_slave) return;
        fc   = frame_buf[1];
        addr = {frame_buf[2], frame_buf[3]};
        qty  = {frame_buf[4], frame_buf[5]};
        cnt  = (my_count < DEPTH) ? my_count : DEPTH;
        rsp.push_back(frame_buf[0]);
        rsp.push_back(fc);
        if (fc != FC_READ && fc != FC_WRITE) begin
            code = EXC_FUNC;
        end else if (addr < my_first || addr >= my_first + cnt) begin
            code = EXC_ADDR;
        end else begin
            offs = addr - my_first;
            if (fc == FC_READ) begin
                if (offs + qty > cnt) begin
                    code = EXC_QTY;
                end else begin
                    rsp.push_back(8'(2 * qty));
                    for (int k = 0; k < qty; k++) begin
                        rsp.push_back(reg_words[offs + k][15:8]);
                        rsp.push_back(reg_words[offs + k][7:0]);
                    end
                end
            end else begin
                bc = frame_buf[6];
                if (bc != 0 && (qty * 2 != bc || bc + 9 > len)) begin
                    code = EXC_QTY;
                end else begin
                    // words before the range end stay written
                    for (int k = 0; k < bc / 2; k++) begin
                        if (offs + k >= cnt) begin
                            code = EXC_QTY;
                            break;
                        end
                        reg_words[offs + k] = {frame_buf[7 + 2 * k], frame_buf[8 + 2 * k]};
                    end
                    if (code == 8'h00) begin
                        for (int k = 2; k < 6; k++) rsp.push_back(frame_buf[k]);
                    end
                end
            end
        end
        if (code != 8'h00) begin
            rsp = {frame_buf[0], fc | EXC_FLAG, code};
        end
        c = CRC_INIT;
        foreach (rsp[k]) c = crc_step(c, rsp[k]);
        rsp.push_back(c[7:0]);
        rsp.push_back(c[15:8]);
        foreach (rsp[k]) begin
            t.tx_byte = rsp[k];
            t.tx_last = (k == rsp.size() - 1);
            response_q.push_back(t);
        end
    endtask

    always @(posedge aclk) begin
        tx_item_t want;
        if (!aresetn) begin
            frame_len = 0;
            frame_ovf = 1'b0;
            rx_crc = CRC_INIT;
            foreach (reg_words[i]) reg_words[i] = 16'h0000;
            my_slave = 8'h00;
            my_first = 16'h0000;
            my_count = 5'd0;
            response_q.delete();
            fail_count = 0;
            results_seen = 0;
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    REG_SLAVE: my_slave = cfg_data[7:0];
                    REG_FIRST: my_first = cfg_data;
                    REG_COUNT: my_count = cfg_data[4:0];
                    default: ;
                endcase
            end
            if (s_valid && s_ready) take_byte(s_data);
            if (m_valid && m_ready) begin
                results_seen++;
                if (response_q.size() == 0) begin
                    $display("%0t: unexpected response item, actual %02h last %0b",
                             $time, m_data.tx_byte, m_data.tx_last);
                    fail_count++;
                end else begin
                    want = response_q.pop_front();
                    if (m_data.tx_byte !== want.tx_byte) begin
                        $display("%0t: tx_byte mismatch, expected %02h actual %02h",
                                 $time, want.tx_byte, m_data.tx_byte);
                        fail_count++;
                    end
                    if (m_data.tx_last !== want.tx_last) begin
                        $display("%0t: tx_last mismatch, expected %0b actual %0b",
                                 $time, want.tx_last, m_data.tx_last);
                        fail_count++;
                    end
                end
            end
        end
        pending = response_q.size();
    end

endmodule

/* bench/tb_modbus_rtu_slave_frame_handler.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_modbus_rtu_slave_frame_handler
// drives request frames (reads, writes, exceptions, dropped frames) through
// several register settings with random idling on both channels
// ----------------------------------------------------------------------------
module tb_modbus_rtu_slave_frame_handler;
    import mbrtu_pkg::*;

    localparam int IDLE_LIMIT = 5000;

    logic       aclk = 1'b0;
    logic       aresetn = 1'b0;
    logic       cfg_we = 1'b0;
    logic [1:0] cfg_index = REG_SLAVE;
    logic [15:0] cfg_data = 16'h0000;
    logic       s_valid = 1'b0;
    logic       s_ready;
    rx_item_t   s_data = '0;
    logic       m_valid;
    logic       m_ready = 1'b0;
    tx_item_t   m_data;

    int  fail_count, pending, results_seen;
    int  idle_cycles = 0;
    int  bytes_sent = 0;
    int  frames_sent = 0;
    int  settings_used = 0;
    int  tx_gap = 0;
    bit  idle_on = 1'b1;

    logic [7:0]  cur_slave = 8'h00;
    logic [15:0] cur_first = 16'h0000;
    int          cur_count = 0;
    logic [7:0]  frm [$];

    modbus_rtu_slave_frame_handler u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
    );

    modbus_rtu_slave_frame_handler_checker u_chk (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .fail_count(fail_count), .pending(pending), .results_seen(results_seen)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (!idle_on || r < 65) return 0;
        if (r < 95) return $urandom_range(1, 3);
        return $urandom_range(10, 50);
    endfunction

    // response side stalls
    always @(negedge aclk) begin
        if (tx_gap > 0) begin
            m_ready <= 1'b0;
            tx_gap <= tx_gap - 1;
        end else begin
            m_ready <= 1'b1;
            tx_gap <= pick_gap();
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || cfg_we) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    function automatic logic [15:0] crc_of(input logic [7:0] q [$]);
        logic [15:0] c;
        c = 16'hFFFF;
        foreach (q[k]) begin
            c = c ^ {8'h00, q[k]};
            for (int i = 0; i < 8; i++) c = c[0] ? ((c >> 1) ^ 16'hA001) : (c >> 1);
        end
        return c;
    endfunction

    task automatic send_byte(input logic [7:0] b, input logic last);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data <= '{rx_byte: b, frame_end: last};
        // s_ready only moves at the rising edge, so its mid-cycle value holds there
        while (!s_ready) @(negedge aclk);
        @(negedge aclk);
        bytes_sent++;
    endtask

    // appends the crc, optionally damaged, and sends the whole frame
    task automatic send_frame(input bit bad_crc);
        logic [15:0] c;
        c = crc_of(frm);
        if (bad_crc) c = c ^ (16'h0001 << $urandom_range(0, 15));
        frm.push_back(c[7:0]);
        frm.push_back(c[15:8]);
        foreach (frm[k]) send_byte(frm[k], k == frm.size() - 1);
        frames_sent++;
    endtask

    task automatic make_read(input logic [7:0] id, input logic [7:0] fc,
                             input logic [15:0] addr, input logic [15:0] qty);
        frm = {id, fc, addr[15:8], addr[7:0], qty[15:8], qty[7:0]};
    endtask

    task automatic make_write(input logic [7:0] id, input logic [15:0] addr,
                              input logic [15:0] qty, input logic [7:0] bc, input int ndata);
        frm = {id, FC_WRITE, addr[15:8], addr[7:0], qty[15:8], qty[7:0], bc};
        repeat (ndata) frm.push_back(8'($urandom));
    endtask

    task automatic write_cfg(input logic [1:0] idx, input logic [15:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(negedge aclk);
        cfg_we <= 1'b0;
    endtask

    task automatic set_regs(input logic [7:0] id, input logic [15:0] first, input int cnt);
        s_valid <= 1'b0;
        while (pending != 0) @(negedge aclk);
        // a dropped frame may still be in the works
        repeat (200) @(negedge aclk);
        write_cfg(REG_SLAVE, {8'h00, id});
        write_cfg(REG_FIRST, first);
        write_cfg(REG_COUNT, 16'(cnt));
        cur_slave = id;
        cur_first = first;
        cur_count = cnt;
        settings_used++;
    endtask

    task automatic random_frame();
        int kind, avail, qty, ndata;
        logic [15:0] addr;
        kind = $urandom_range(0, 99);
        if (cur_count > 0 && $urandom_range(0, 99) < 80) begin
            avail = $urandom_range(0, cur_count - 1);
            addr = cur_first + 16'(avail);
            avail = cur_count - avail;
        end else begin
            case ($urandom_range(0, 2))
                0: addr = cur_first - 16'd1;
                1: addr = cur_first + 16'(cur_count);
                default: addr = 16'($urandom);
            endcase
            avail = 3;
        end
        qty = ($urandom_range(0, 99) < 85) ? $urandom_range(0, avail) : avail + $urandom_range(1, 2);
        if (qty > 16) qty = 16;
        if (kind < 35) begin
            if ($urandom_range(0, 19) == 0) qty = $urandom;
            make_read(cur_slave, FC_READ, addr, 16'(qty));
            send_frame(0);
        end else if (kind < 65) begin
            case ($urandom_range(0, 9))
                0: make_write(cur_slave, addr, 16'($urandom_range(0, 16)), 8'h00, 0);
                1: make_write(cur_slave, addr, 16'(qty), 8'(2 * qty + 1), 2 * qty + 1);
                2: make_write(cur_slave, addr, 16'(qty + 1), 8'(2 * qty + 2), 2 * qty);
                default: make_write(cur_slave, addr, 16'(qty), 8'(2 * qty), 2 * qty);
            endcase
            send_frame(0);
        end else if (kind < 72) begin
            make_read(cur_slave, 8'($urandom), addr, 16'(qty));
            send_frame(0);
        end else if (kind < 78) begin
            ndata = $urandom_range(1, 7);
            frm.delete();
            repeat (ndata) frm.push_back(8'($urandom));
            foreach (frm[k]) send_byte(frm[k], k == frm.size() - 1);
        end else if (kind < 84) begin
            make_read(cur_slave, FC_READ, addr, 16'(qty));
            send_frame(1);
        end else if (kind < 89) begin
            make_read(cur_slave ^ 8'($urandom_range(1, 255)), FC_READ, addr, 16'(qty));
            send_frame(0);
        end else if (kind < 93) begin
            make_write(cur_slave, addr, 16'(qty), 8'(2 * qty), $urandom_range(60, 70));
            send_frame(0);
        end else begin
            ndata = $urandom_range(1, 12);
            repeat (ndata) send_byte(8'($urandom), $urandom_range(0, 3) == 0);
        end
    endtask

    initial begin
        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // directed frames
        set_regs(8'h00, 16'h0000, 16);
        make_write(8'h00, 16'h0000, 16'd2, 8'd4, 0);
        frm = {frm, 8'hFF, 8'hFF, 8'h00, 8'h00};
        send_frame(0);
        make_read(8'h00, FC_READ, 16'h0000, 16'd3);
        send_frame(0);
        make_read(8'h00, FC_READ, 16'h000F, 16'd0);
        send_frame(0);
        make_read(8'h00, 8'h04, 16'h0000, 16'd1);
        send_frame(0);
        make_read(8'h00, FC_READ, 16'h0010, 16'd1);
        send_frame(0);
        make_read(8'h00, FC_READ, 16'h000F, 16'd2);
        send_frame(0);
        make_write(8'h00, 16'h0002, 16'd5, 8'd0, 0);
        send_frame(0);
        make_write(8'h00, 16'h000E, 16'd3, 8'd6, 6);
        send_frame(0);
        make_read(8'h00, FC_READ, 16'h0000, 16'd16);
        send_frame(0);
        make_read(8'h00, FC_READ, 16'h0000, 16'd1);
        send_frame(1);
        make_write(8'h00, 16'h0000, 16'd1, 8'd2, 70);
        send_frame(0);

        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                0: set_regs(8'hFF, 16'hFFF0, 16);
                1: set_regs(8'($urandom), 16'hFFFF, 1);
                2: set_regs(8'($urandom), 16'($urandom), 0);
                3: set_regs(8'($urandom), 16'($urandom_range(0, 200)), $urandom_range(1, 15));
                4: set_regs(8'h5A, 16'h0000, 16);
                default: set_regs(8'($urandom), 16'($urandom), $urandom_range(2, 16));
            endcase
            idle_on = (ph != 4);
            while (bytes_sent < 170 + 40 * (ph + 1)) random_frame();
        end
        idle_on = 1'b1;
        s_valid <= 1'b0;
        while (pending != 0) @(posedge aclk);
        repeat (200) @(posedge aclk);

        $display("%0d frames, %0d request bytes and %0d response bytes checked",
                 frames_sent, bytes_sent, results_seen);
        $display("across %0d register settings", settings_used);
        if (fail_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
